>>> sv/sodcrc_pkg.sv
// ----------------------------------------------------------------------------
// sodcrc_pkg
// Shared widths, register indexes, reset values and the CRC-8 step function
// for the start-byte framed receiver.
// ----------------------------------------------------------------------------
package sodcrc_pkg;

  // Frame geometry.
  localparam int PAYLOAD_LEN = 3;
  localparam int ADDR_W      = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(PAYLOAD_LEN - 1);

  // Field widths.
  localparam int BYTE_W    = 8;
  localparam int SLOT_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_BYTE  = 2'd3;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h00;
  localparam logic [BYTE_W-1:0] CRC_POLY_RST   = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_SEED_RST   = 8'h00;
  localparam logic [BYTE_W-1:0] FILL_BYTE_RST  = 8'h00;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] crc_poly;
    logic [BYTE_W-1:0] crc_seed;
    logic [BYTE_W-1:0] fill_byte;
  } cfg_t;

  // One byte of an MSB-first CRC-8, no reflection, no final xor.
  function automatic logic [BYTE_W-1:0] crc8_update(
    input logic [BYTE_W-1:0] crc,
    input logic [BYTE_W-1:0] data,
    input logic [BYTE_W-1:0] poly
  );
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/sodcrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// sodcrc_cfg_regs
// Configuration register file: start byte, CRC polynomial, CRC seed and
// fill byte, written through a plain write port.
// ----------------------------------------------------------------------------
module sodcrc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sodcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sodcrc_pkg::BYTE_W-1:0]      cfg_data,
  output sodcrc_pkg::cfg_t                   cfg
);
  import sodcrc_pkg::*;

  // Register writes; every index of the port maps to a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_BYTE_RST;
      cfg.crc_poly   <= CRC_POLY_RST;
      cfg.crc_seed   <= CRC_SEED_RST;
      cfg.fill_byte  <= FILL_BYTE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_BYTE: cfg.start_byte <= cfg_data;
        CFG_CRC_POLY:   cfg.crc_poly   <= cfg_data;
        CFG_CRC_SEED:   cfg.crc_seed   <= cfg_data;
        CFG_FILL_BYTE:  cfg.fill_byte  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/sodcrc_payload_ram.sv
// ----------------------------------------------------------------------------
// sodcrc_payload_ram
// Payload buffer: one write port and one read port with registered read
// data. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module sodcrc_payload_ram (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [sodcrc_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [sodcrc_pkg::BYTE_W-1:0]    wr_data,
  input  logic                             rd_en,
  input  logic [sodcrc_pkg::ADDR_W-1:0]    rd_addr,
  output logic [sodcrc_pkg::BYTE_W-1:0]    rd_data
);
  import sodcrc_pkg::*;

  logic [BYTE_W-1:0] mem [PAYLOAD_LEN];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/sod_crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// sod_crc8_frame_receiver
// Hunts for a start byte, buffers a fixed-length payload while running a
// CRC-8 over it, checks the following CRC byte and plays the frame out.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on rx_byte with in_valid/in_stall; a transfer happens
// at an edge where in_valid is high and in_stall is low. Each frame is a
// start byte, PAYLOAD_LEN payload bytes and one CRC byte. The payload is
// kept in a small synchronous RAM. After the CRC byte the block raises
// in_stall and reads the RAM back: each result takes a read state (S_READ)
// and then a wait state (S_WAIT) that moves the read data into the output
// register once that register is free, and results keep coming while
// out_stall is low. The last result carries last_byte; the block then
// hunts again and accepts input while that result still waits.
// If the receiver holds out_stall, the output register holds its result and
// playback pauses on the RAM read data. Reset puts the block in the hunting
// state with an empty output register and the configuration registers at
// their defaults; the payload RAM needs no clearing. Configuration is
// written via cfg_wr_en.
// ----------------------------------------------------------------------------
module sod_crc8_frame_receiver (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [sodcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sodcrc_pkg::BYTE_W-1:0]     cfg_data,
  // Received byte channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sodcrc_pkg::BYTE_W-1:0]     rx_byte,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sodcrc_pkg::BYTE_W-1:0]     data_byte,
  output logic [sodcrc_pkg::SLOT_W-1:0]     slot_index,
  output logic                              frame_ok,
  output logic                              last_byte
);
  import sodcrc_pkg::*;

  typedef enum logic [4:0] {
    S_HUNT = 5'b00001,
    S_LOAD = 5'b00010,
    S_CRC  = 5'b00100,
    S_READ = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  cfg_t              cfg;
  state_t            state, state_next;
  logic [ADDR_W-1:0] slot;
  logic [BYTE_W-1:0] running_crc;
  logic              frame_ok_lat;
  logic [BYTE_W-1:0] fill_lat;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic              out_load;
  logic              in_xfer;
  logic              out_free;
  logic              slot_last;
  logic              start_hit;

  sodcrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sodcrc_payload_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot),
    .wr_data (rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  // Input is taken only while receiving; playback holds it off.
  assign in_stall  = !(state == S_HUNT || state == S_LOAD || state == S_CRC);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign slot_last = (slot == LAST_SLOT);
  assign start_hit = in_xfer && (state == S_HUNT) && (rx_byte == cfg.start_byte);

  // Frame sequencer.
  always_comb begin
    state_next = state;
    ram_wr_en  = 1'b0;
    ram_rd_en  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_HUNT: begin
        if (start_hit) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (in_xfer) begin
          ram_wr_en = 1'b1;
          if (slot_last) begin
            state_next = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (in_xfer) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        ram_rd_en  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = slot_last ? S_HUNT : S_READ;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  // State, slot counter and running CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_HUNT;
      slot        <= '0;
      running_crc <= '0;
    end else begin
      state <= state_next;
      if (start_hit) begin
        slot        <= '0;
        running_crc <= cfg.crc_seed;
      end else if (ram_wr_en || out_load) begin
        slot <= slot_last ? '0 : slot + ADDR_W'(1);
      end
      if (ram_wr_en) begin
        running_crc <= crc8_update(running_crc, rx_byte, cfg.crc_poly);
      end
    end
  end

  // Check verdict and fill byte, captured with the CRC byte.
  always_ff @(posedge clk) begin
    if (in_xfer && state == S_CRC) begin
      frame_ok_lat <= (rx_byte == running_crc);
      fill_lat     <= cfg.fill_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_byte  <= frame_ok_lat ? ram_rd_data : fill_lat;
      slot_index <= SLOT_W'(slot);
      frame_ok   <= frame_ok_lat;
      last_byte  <= slot_last;
    end
  end

  // The last result of a frame always sits in the final payload slot.
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> slot_index == SLOT_W'(PAYLOAD_LEN - 1))
    else $error("last_byte on a slot other than the final one");

  // A failed frame reports the fill byte captured with its CRC byte.
  a_fill_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_load && !frame_ok_lat |=> data_byte == $past(fill_lat))
    else $error("failed frame did not report the fill byte");

  // The CRC byte transfer starts playback from the first slot.
  a_playback_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && state == S_CRC |=> state == S_READ && slot == '0)
    else $error("playback did not start at slot zero");

endmodule
